// ===== rtl/unique_key_compacting_table_macros.svh =====
// Assertion macros shared by the table logic.
`ifndef UNIQUE_KEY_COMPACTING_TABLE_MACROS_SVH
`define UNIQUE_KEY_COMPACTING_TABLE_MACROS_SVH

// Antecedent and consequent in the same cycle, checked out of reset.
`define UKCT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UKCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ukct_pkg.sv =====
`timescale 1ns / 1ps
package ukct_pkg;

    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 6;
    localparam int CNT_OUT_W = 7;
    localparam int CAP_W     = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2
    } ukct_mode_t;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    // Commands broadcast along the row of cells.
    typedef struct packed {
        logic compare;
        logic insert;
        logic remove;
    } ukct_cell_ctrl_t;

endpackage

// ===== rtl/ukct_cell.sv =====
`timescale 1ns / 1ps
module ukct_cell
    import ukct_pkg::*;
#(
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16,
    parameter int IDX_W        = 6,
    parameter int CNT_W        = 7,
    parameter int CELL_INDEX   = 0
) (
    input  logic                    aclk,
    input  ukct_cell_ctrl_t         ctrl,
    input  logic [KEY_BITS-1:0]     bcast_key,
    input  logic [PAYLOAD_BITS-1:0] bcast_payload,
    input  logic [CNT_W-1:0]        count,
    input  logic [IDX_W-1:0]        remove_pos,
    input  logic [KEY_BITS-1:0]     next_key,
    input  logic [PAYLOAD_BITS-1:0] next_payload,
    output logic [KEY_BITS-1:0]     key,
    output logic [PAYLOAD_BITS-1:0] payload,
    output logic                    match
);

    localparam logic [CNT_W-1:0] CELL_CNT = CNT_W'(CELL_INDEX);
    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(CELL_INDEX);

    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic                    match_reg, match_next;

    always_comb begin
        key_next     = key_reg;
        payload_next = payload_reg;
        match_next   = match_reg;
        if (ctrl.compare) begin
            // Only cells below the fill level hold live entries.
            match_next = (key_reg == bcast_key) && (CELL_CNT < count);
        end
        if (ctrl.insert && (CELL_CNT == count)) begin
            key_next     = bcast_key;
            payload_next = bcast_payload;
        end
        if (ctrl.remove && (CELL_IDX >= remove_pos)) begin
            // Close the gap: everything from the removed slot up moves down one.
            key_next     = next_key;
            payload_next = next_payload;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
        match_reg   <= match_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;
    assign match   = match_reg;

endmodule

// ===== rtl/unique_key_compacting_table.sv =====
// A word is taken only in the idle state. The row of cells compares on the accept edge, the
// match vector is encoded into registers, then, once the result side can take a result, the
// row is updated and the result loaded onto m_valid. No new word is taken until that commit.
// Reset (synchronous, active low): table empty, capacity at the table depth but at most 64, no result
// pending. Stored keys and payloads are not cleared.
`timescale 1ns / 1ps
`include "unique_key_compacting_table_macros.svh"
module unique_key_compacting_table
    import ukct_pkg::*;
#(
    parameter int TABLE_DEPTH  = 64,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CAP_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [MODE_W-1:0]       s_mode,
    input  logic [KEY_BITS-1:0]     s_entry_key,
    input  logic [PAYLOAD_BITS-1:0] s_entry_payload,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STATUS_W-1:0]     m_status,
    output logic [PAYLOAD_BITS-1:0] m_found_payload,
    output logic [POS_W-1:0]        m_position,
    output logic [CNT_OUT_W-1:0]    m_entry_count,
    output logic                    m_is_full,
    output logic                    m_is_empty
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam int CAP_RESET_VAL = (TABLE_DEPTH < 64) ? TABLE_DEPTH : 64;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_RESOLVE = 3'b010,
        ST_COMMIT  = 3'b100
    } ukct_state_t;

    ukct_state_t state_reg, state_next;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        cap_reg, cap_next;
    logic [MODE_W-1:0]       op_mode_reg;
    logic [KEY_BITS-1:0]     op_key_reg;
    logic [PAYLOAD_BITS-1:0] op_payload_reg;

    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [PAYLOAD_BITS-1:0] found_reg, found_next;

    logic                    m_valid_reg;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [PAYLOAD_BITS-1:0] m_found_reg, m_found_next;
    logic [POS_W-1:0]        m_pos_reg, m_pos_next;
    logic [CNT_OUT_W-1:0]    m_count_reg, m_count_next;
    logic                    m_full_reg, m_full_next;
    logic                    m_empty_reg, m_empty_next;

    logic                    accept;
    logic                    commit_go;
    logic                    insert_ok;
    logic [IDX_W-1:0]        res_pos;
    logic [IDX_W+POS_W-1:0]  pos_wide;
    logic [CNT_W+CNT_OUT_W-1:0] count_wide;

    ukct_cell_ctrl_t         cell_ctrl;
    logic [KEY_BITS-1:0]     bcast_key;
    logic [KEY_BITS-1:0]     cell_key     [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_payload [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  match_vec;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign commit_go = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);
    assign insert_ok = (op_mode_reg == MODE_INSERT) && (count_reg < cap_reg) && !hit_reg;

    // The compare runs on the accept edge, so the key comes straight from the port then.
    assign bcast_key = (state_reg == ST_IDLE) ? s_entry_key : op_key_reg;

    always_comb begin
        cell_ctrl.compare = accept;
        cell_ctrl.insert  = commit_go && insert_ok;
        cell_ctrl.remove  = commit_go && (op_mode_reg == MODE_REMOVE) && hit_reg;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        if (i == TABLE_DEPTH - 1) begin : g_last
            ukct_cell #(
                .KEY_BITS     (KEY_BITS),
                .PAYLOAD_BITS (PAYLOAD_BITS),
                .IDX_W        (IDX_W),
                .CNT_W        (CNT_W),
                .CELL_INDEX   (i)
            ) u_cell (
                .aclk          (aclk),
                .ctrl          (cell_ctrl),
                .bcast_key     (bcast_key),
                .bcast_payload (op_payload_reg),
                .count         (count_reg),
                .remove_pos    (pos_reg),
                .next_key      (cell_key[i]),
                .next_payload  (cell_payload[i]),
                .key           (cell_key[i]),
                .payload       (cell_payload[i]),
                .match         (match_vec[i])
            );
        end else begin : g_mid
            ukct_cell #(
                .KEY_BITS     (KEY_BITS),
                .PAYLOAD_BITS (PAYLOAD_BITS),
                .IDX_W        (IDX_W),
                .CNT_W        (CNT_W),
                .CELL_INDEX   (i)
            ) u_cell (
                .aclk          (aclk),
                .ctrl          (cell_ctrl),
                .bcast_key     (bcast_key),
                .bcast_payload (op_payload_reg),
                .count         (count_reg),
                .remove_pos    (pos_reg),
                .next_key      (cell_key[i+1]),
                .next_payload  (cell_payload[i+1]),
                .key           (cell_key[i]),
                .payload       (cell_payload[i]),
                .match         (match_vec[i])
            );
        end
    end

    // Keys are unique among live entries, so at most one match bit is set and
    // plain OR trees give the index and payload.
    always_comb begin
        hit_next   = |match_vec;
        pos_next   = '0;
        found_next = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            pos_next   = pos_next | (match_vec[i] ? IDX_W'(i) : '0);
            found_next = found_next | (match_vec[i] ? cell_payload[i] : '0);
        end
    end

    always_comb begin
        cap_next = cap_reg;
        if (cfg_wr_en) begin
            if ((cfg_wr_data == '0) || (32'(cfg_wr_data) > TABLE_DEPTH)) begin
                cap_next = DEPTH_CNT;
            end else begin
                cap_next = CNT_W'(cfg_wr_data);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (commit_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        count_next    = count_reg;
        m_status_next = STATUS_DONE;
        m_found_next  = '0;
        res_pos       = '0;
        unique case (op_mode_reg)
            MODE_INSERT: begin
                if (count_reg >= cap_reg) begin
                    m_status_next = STATUS_FULL;
                end else if (hit_reg) begin
                    m_status_next = STATUS_DUPLICATE;
                    res_pos       = pos_reg;
                end else begin
                    res_pos    = IDX_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_LOOKUP: begin
                if (hit_reg) begin
                    m_found_next = found_reg;
                    res_pos      = pos_reg;
                end else begin
                    m_status_next = STATUS_NOT_FOUND;
                end
            end
            MODE_REMOVE: begin
                if (hit_reg) begin
                    res_pos    = pos_reg;
                    count_next = count_reg - 1'b1;
                end else begin
                    m_status_next = STATUS_NOT_FOUND;
                end
            end
            default: begin
                m_status_next = STATUS_DONE;
            end
        endcase
        pos_wide     = {{POS_W{1'b0}}, res_pos};
        count_wide   = {{CNT_OUT_W{1'b0}}, count_next};
        m_pos_next   = pos_wide[POS_W-1:0];
        m_count_next = count_wide[CNT_OUT_W-1:0];
        m_full_next  = (count_next >= cap_reg);
        m_empty_next = (count_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cap_reg     <= CNT_W'(CAP_RESET_VAL);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            if (commit_go) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_mode_reg    <= s_mode;
            op_key_reg     <= s_entry_key;
            op_payload_reg <= s_entry_payload;
        end
        if (state_reg == ST_RESOLVE) begin
            hit_reg   <= hit_next;
            pos_reg   <= pos_next;
            found_reg <= found_next;
        end
        if (commit_go) begin
            m_status_reg <= m_status_next;
            m_found_reg  <= m_found_next;
            m_pos_reg    <= m_pos_next;
            m_count_reg  <= m_count_next;
            m_full_reg   <= m_full_next;
            m_empty_reg  <= m_empty_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_found_payload = m_found_reg;
    assign m_position      = m_pos_reg;
    assign m_entry_count   = m_count_reg;
    assign m_is_full       = m_full_reg;
    assign m_is_empty      = m_empty_reg;

    `UKCT_ASSERT_SAME(a_count_bound, 1'b1, 32'(count_reg) <= TABLE_DEPTH, "entry count above depth")
    `UKCT_ASSERT_SAME(a_match_unique, state_reg == ST_RESOLVE, $onehot0(match_vec), "key matched twice")
    `UKCT_ASSERT_NEXT(a_accept_resolve, accept, state_reg == ST_RESOLVE, "accept did not start a search")
    `UKCT_ASSERT_NEXT(a_commit_result, commit_go, m_valid_reg && state_reg == ST_IDLE, "commit lost result")

endmodule

// ===== sim/tb_unique_key_compacting_table.sv =====
`timescale 1ns / 1ps
module tb_unique_key_compacting_table;
    import ukct_pkg::*;

    localparam int DEPTH        = 64;
    localparam int KEY_W        = 16;
    localparam int PAY_W        = 16;
    localparam int DUT_LATENCY  = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 100;
    localparam int NUM_PHASES   = 8;
    localparam int POOL_SIZE    = 80;
    localparam int MAX_REPORTS  = 10;

    // The mode field has one code that the package leaves unnamed; the table ignores it.
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    localparam int PHASE_CAP [NUM_PHASES] = '{64, 127, 3, 1, 0, 40, 65, 64};
    localparam int PHASE_INS [NUM_PHASES] = '{70, 75, 35, 30, 60, 45, 55, 45};

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CAP_W-1:0]        cfg_wr_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [MODE_W-1:0]       s_mode;
    logic [KEY_W-1:0]        s_entry_key;
    logic [PAY_W-1:0]        s_entry_payload;
    logic                    m_valid;
    logic                    m_ready;
    logic [STATUS_W-1:0]     m_status;
    logic [PAY_W-1:0]        m_found_payload;
    logic [POS_W-1:0]        m_position;
    logic [CNT_OUT_W-1:0]    m_entry_count;
    logic                    m_is_full;
    logic                    m_is_empty;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PAY_W-1:0]     found_payload;
        logic [POS_W-1:0]     position;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 is_full;
        logic                 is_empty;
    } table_result_t;

    class table_scoreboard;
        logic [KEY_W-1:0] key_tbl [DEPTH];
        logic [PAY_W-1:0] pay_tbl [DEPTH];
        int               fill;
        logic [CAP_W-1:0] cap_reg;
        table_result_t    expected_q [$];
        int               mismatches;

        function void clear();
            fill = 0;
            cap_reg = 7'd64;
            mismatches = 0;
            expected_q.delete();
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            cap_reg = value;
        endfunction

        // Zero and anything above the depth both mean the whole table.
        function int usable_capacity();
            if (cap_reg == 0 || cap_reg > DEPTH)
                return DEPTH;
            return int'(cap_reg);
        endfunction

        function int find_entry(logic [KEY_W-1:0] key);
            for (int i = 0; i < fill; i++)
                if (key_tbl[i] == key)
                    return i;
            return -1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [KEY_W-1:0] pick_stored_key();
            if (fill == 0)
                return KEY_W'($urandom);
            return key_tbl[$urandom_range(0, fill - 1)];
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                   logic [PAY_W-1:0] pay);
            table_result_t r;
            int            cap;
            int            idx;
            r = '0;
            r.status = STATUS_DONE;
            cap = usable_capacity();
            idx = find_entry(key);
            case (mode)
                MODE_INSERT: begin
                    // The full check wins over the duplicate check.
                    if (fill >= cap) begin
                        r.status = STATUS_FULL;
                    end else if (idx >= 0) begin
                        r.status = STATUS_DUPLICATE;
                        r.position = POS_W'(idx);
                    end else begin
                        key_tbl[fill] = key;
                        pay_tbl[fill] = pay;
                        r.position = POS_W'(fill);
                        fill++;
                    end
                end
                MODE_LOOKUP: begin
                    if (idx >= 0) begin
                        r.found_payload = pay_tbl[idx];
                        r.position = POS_W'(idx);
                    end else begin
                        r.status = STATUS_NOT_FOUND;
                    end
                end
                MODE_REMOVE: begin
                    if (idx >= 0) begin
                        for (int i = idx; i + 1 < fill; i++) begin
                            key_tbl[i] = key_tbl[i + 1];
                            pay_tbl[i] = pay_tbl[i + 1];
                        end
                        fill--;
                        r.position = POS_W'(idx);
                    end else begin
                        r.status = STATUS_NOT_FOUND;
                    end
                end
                default: begin
                end
            endcase
            r.entry_count = CNT_OUT_W'(fill);
            r.is_full = (fill >= cap);
            r.is_empty = (fill == 0);
            expected_q.push_back(r);
        endfunction

        function void check_result(table_result_t got);
            table_result_t exp_r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word at %0t: status %0d payload %h pos %0d",
                             $realtime, got.status, got.found_payload, got.position);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.status != exp_r.status || got.found_payload != exp_r.found_payload ||
                got.position != exp_r.position || got.entry_count != exp_r.entry_count ||
                got.is_full != exp_r.is_full || got.is_empty != exp_r.is_empty) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected: status %0d payload %h pos %0d count %0d full %0d empty %0d",
                             exp_r.status, exp_r.found_payload, exp_r.position,
                             exp_r.entry_count, exp_r.is_full, exp_r.is_empty);
                    $display("  actual:   status %0d payload %h pos %0d count %0d full %0d empty %0d",
                             got.status, got.found_payload, got.position,
                             got.entry_count, got.is_full, got.is_empty);
                end
            end
        endfunction
    endclass

    table_scoreboard  sb;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    bit               idle_on;
    bit               long_hold_req;
    int               cycle_cnt;

    unique_key_compacting_table #(
        .TABLE_DEPTH  (DEPTH),
        .KEY_BITS     (KEY_W),
        .PAYLOAD_BITS (PAY_W)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_entry_key     (s_entry_key),
        .s_entry_payload (s_entry_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_payload (m_found_payload),
        .m_position      (m_position),
        .m_entry_count   (m_entry_count),
        .m_is_full       (m_is_full),
        .m_is_empty      (m_is_empty)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Both handshakes are sampled here with the values they had at the edge.
    always @(posedge aclk) begin : monitor
        table_result_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.status = m_status;
                got.found_payload = m_found_payload;
                got.position = m_position;
                got.entry_count = m_entry_count;
                got.is_full = m_is_full;
                got.is_empty = m_is_empty;
                sb.check_result(got);
            end
            if (s_valid && s_ready)
                sb.note_request(s_mode, s_entry_key, s_entry_payload);
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_word(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                             logic [PAY_W-1:0] pay);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_entry_key <= key;
        s_entry_payload <= pay;
        do @(posedge aclk); while (!s_ready);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Stop offering words and wait until every result is back and the pipe is empty.
    task automatic wait_table_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DUT_LATENCY) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_table_quiet();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_capacity(value);
        @(posedge aclk);
    endtask

    task automatic send_random_word(int insert_pct);
        int               pick;
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < insert_pct) begin
            mode = MODE_INSERT;
            if ($urandom_range(0, 4) == 0)
                key = KEY_W'($urandom);
            else
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 97) begin
            mode = ($urandom_range(0, 1) == 0) ? MODE_LOOKUP : MODE_REMOVE;
            // Mostly keys that are present, so lookups hit and removes shift the table.
            if ($urandom_range(0, 3) != 0)
                key = sb.pick_stored_key();
            else
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            mode = MODE_NOP;
            key = KEY_W'($urandom);
        end
        send_word(mode, key, PAY_W'($urandom));
    endtask

    initial begin
        sb = new;
        sb.clear();
        cycle_cnt = 0;
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_mode <= MODE_INSERT;
        s_entry_key <= '0;
        s_entry_payload <= '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty table, extremes, duplicates, compaction, capacity corners.
        send_word(MODE_LOOKUP, 16'h0000, 16'h0000);
        send_word(MODE_REMOVE, 16'hFFFF, 16'hFFFF);
        send_word(MODE_INSERT, 16'h0000, 16'hFFFF);
        send_word(MODE_INSERT, 16'hFFFF, 16'h0000);
        send_word(MODE_INSERT, 16'h0000, 16'h1234);
        send_word(MODE_LOOKUP, 16'hFFFF, 16'h0000);
        send_word(MODE_LOOKUP, 16'h0000, 16'h0000);
        send_word(MODE_NOP, 16'hFFFF, 16'hFFFF);
        send_word(MODE_REMOVE, 16'h0000, 16'h0000);
        send_word(MODE_LOOKUP, 16'hFFFF, 16'h0000);
        write_capacity(7'd1);
        send_word(MODE_INSERT, 16'h1234, 16'h5555);
        send_word(MODE_INSERT, 16'hFFFF, 16'hAAAA);
        send_word(MODE_REMOVE, 16'hFFFF, 16'h0000);
        send_word(MODE_INSERT, 16'h1234, 16'hA5A5);
        write_capacity(7'd64);
        send_word(MODE_INSERT, 16'h0001, 16'h0101);
        send_word(MODE_INSERT, 16'h0002, 16'h0202);
        send_word(MODE_INSERT, 16'h0004, 16'h0404);
        send_word(MODE_INSERT, 16'h0008, 16'h0808);
        // Capacity now sits below the count: inserts bounce, the rest still works.
        write_capacity(7'd2);
        send_word(MODE_INSERT, 16'h0010, 16'h1010);
        send_word(MODE_LOOKUP, 16'h0004, 16'h0000);
        send_word(MODE_REMOVE, 16'h0002, 16'h0000);
        write_capacity(7'd0);
        send_word(MODE_INSERT, 16'h0010, 16'h1010);
        write_capacity(7'd127);
        send_word(MODE_INSERT, 16'h0020, 16'h2020);
        send_word(MODE_REMOVE, 16'h1234, 16'h0000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(CAP_W'(PHASE_CAP[p]));
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            if (p == 1)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_word(PHASE_INS[p]);
                // One pause in the middle of a phase with the table left as it is.
                if (p == 3 && n == PHASE_ITEMS / 2)
                    wait_table_quiet();
            end
        end

        wait_table_quiet();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
